@@ design/rgbseq_pkg.sv @@
`timescale 1ns / 1ps

package rgbseq_pkg;

    // chain geometry
    localparam int MAX_LEDS   = 256;
    localparam int CHUNK_LEDS = 8;
    localparam int BITS_PER_LED = 24;
    localparam int CHUNK_SYMS = CHUNK_LEDS * BITS_PER_LED;

    // widths
    localparam int LED_W   = 9;
    localparam int TICK_W  = 8;
    localparam int BIT_W   = $clog2(BITS_PER_LED);
    localparam int SLOT_W  = (CHUNK_SYMS > 1) ? $clog2(CHUNK_SYMS) : 1;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 9;

    localparam logic [LED_W-1:0]  MAX_LEDS_V  = LED_W'(MAX_LEDS);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(CHUNK_SYMS - 1);
    localparam logic [BIT_W-1:0]  LAST_BIT    = BIT_W'(BITS_PER_LED - 1);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_CHAIN_LEN = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_ZERO_HIGH = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SOURCE    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RED       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_GREEN     = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_BLUE      = 3'd6;

    // register reset values
    localparam logic [LED_W-1:0]  CHAIN_LEN_RST = 9'd1;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd58;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd115;

    // operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // status codes
    localparam logic [1:0] ST_TICK    = 2'd0;
    localparam logic [1:0] ST_STARTED = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // frame phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_PAD  = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    typedef struct packed {
        logic [LED_W-1:0]  chain_len;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_high;
        logic              source;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] symbol_ticks;
        logic [1:0]        status;
        logic              busy_res;
        logic              pixel_wanted;
        logic [7:0]        next_pixel_index;
        logic              frame_done;
    } t_res;

endpackage

@@ design/rgbseq_in_if.sv @@
`timescale 1ns / 1ps

interface rgbseq_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (
        output valid, operation, pixel_red, pixel_green, pixel_blue,
        input  ready
    );
    modport sink (
        input  valid, operation, pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

@@ design/rgbseq_out_if.sv @@
`timescale 1ns / 1ps

interface rgbseq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_ticks;
    logic [1:0] status;
    logic       busy_res;
    logic       pixel_wanted;
    logic [7:0] next_pixel_index;
    logic       frame_done;

    modport source (
        output valid, symbol_ticks, status, busy_res, pixel_wanted,
               next_pixel_index, frame_done,
        input  ready
    );
    modport sink (
        input  valid, symbol_ticks, status, busy_res, pixel_wanted,
               next_pixel_index, frame_done,
        output ready
    );
endinterface

@@ design/rgbseq_cfg.sv @@
`timescale 1ns / 1ps

module rgbseq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rgbseq_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [rgbseq_pkg::CDATA_W-1:0] i_cfg_data,
    output rgbseq_pkg::t_cfg               o_cfg
);
    import rgbseq_pkg::*;

    t_cfg             r_cfg;
    logic [LED_W-1:0] w_count;

    // zero becomes one, anything past MAX_LEDS saturates
    always_comb begin
        w_count = i_cfg_data[LED_W-1:0];
        if (w_count == '0) begin
            w_count = LED_W'(1);
        end else if (w_count > MAX_LEDS_V) begin
            w_count = MAX_LEDS_V;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chain_len <= CHAIN_LEN_RST;
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.source    <= 1'b0;
            r_cfg.red       <= '0;
            r_cfg.green     <= '0;
            r_cfg.blue      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHAIN_LEN: r_cfg.chain_len <= w_count;
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[TICK_W-1:0];
                CFG_SOURCE:    r_cfg.source    <= i_cfg_data[0];
                CFG_RED:       r_cfg.red       <= i_cfg_data[7:0];
                CFG_GREEN:     r_cfg.green     <= i_cfg_data[7:0];
                CFG_BLUE:      r_cfg.blue      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/rgbseq_core.sv @@
`timescale 1ns / 1ps

module rgbseq_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_operation,
    input  logic [7:0]       i_pixel_red,
    input  logic [7:0]       i_pixel_green,
    input  logic [7:0]       i_pixel_blue,
    input  rgbseq_pkg::t_cfg i_cfg,
    output rgbseq_pkg::t_res o_res
);
    import rgbseq_pkg::*;

    logic [1:0]          r_phase, n_phase;
    logic [LED_W-1:0]    r_led, n_led;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [23:0]         r_shift, n_shift;
    logic [SLOT_W-1:0]   r_slot, n_slot;

    logic [23:0]         w_colour;
    logic [SLOT_W-1:0]   w_slot_inc;
    logic [LED_W-1:0]    w_led_inc;

    assign w_slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
    assign w_led_inc  = r_led + LED_W'(1);

    always_comb begin
        if (r_bit == '0) begin
            if (i_cfg.source) begin
                w_colour = {i_pixel_green, i_pixel_red, i_pixel_blue};
            end else begin
                w_colour = {i_cfg.green, i_cfg.red, i_cfg.blue};
            end
        end else begin
            w_colour = r_shift;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_led   = r_led;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_slot  = r_slot;
        o_res.symbol_ticks = '0;
        o_res.status       = ST_TICK;
        o_res.frame_done   = 1'b0;

        if (i_operation == OP_START) begin
            if (r_phase != PH_IDLE) begin
                o_res.status = ST_REFUSED;
            end else begin
                o_res.status = ST_STARTED;
                n_phase = PH_DATA;
                n_led   = '0;
                n_bit   = '0;
                n_shift = '0;
                n_slot  = '0;
            end
        end else begin
            unique case (r_phase)
                PH_DATA: begin
                    o_res.symbol_ticks = w_colour[23] ? i_cfg.one_high : i_cfg.zero_high;
                    n_shift = {w_colour[22:0], 1'b0};
                    n_slot  = w_slot_inc;
                    if (r_bit == LAST_BIT) begin
                        n_bit = '0;
                        n_led = w_led_inc;
                        if (w_led_inc >= i_cfg.chain_len) begin
                            n_phase = (w_slot_inc == '0) ? PH_LOW : PH_PAD;
                        end
                    end else begin
                        n_bit = r_bit + BIT_W'(1);
                    end
                end
                PH_PAD: begin
                    n_slot = w_slot_inc;
                    if (w_slot_inc == '0) begin
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    n_slot = w_slot_inc;
                    if (w_slot_inc == '0) begin
                        n_phase = PH_IDLE;
                        o_res.frame_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        o_res.busy_res         = (n_phase != PH_IDLE);
        o_res.pixel_wanted     = (n_phase == PH_DATA) && (n_bit == '0) && i_cfg.source;
        o_res.next_pixel_index = (n_phase == PH_DATA) ? n_led[7:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_led   <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_slot  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_led   <= n_led;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_slot  <= n_slot;
        end
    end

endmodule

@@ design/rgb_led_bit_slot_sequencer_top.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// i_in      in   valid/ready    operation, pixel_red, pixel_green, pixel_blue
// o_out     out  valid/ready    symbol_ticks, status, busy_res, pixel_wanted,
//                               next_pixel_index, frame_done
// i_cfg_*   in   write enable   register index, write data
//
// one request per cycle while ready is high; its result is registered and shows in the cycle after acceptance
// the result register is refilled in the cycle it is taken, so ready only
// drops while a result sits unclaimed and the sink holds off
// synchronous active-low reset; frame idle, registers at their defaults

module rgb_led_bit_slot_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rgbseq_in_if.sink                      i_in,
    rgbseq_out_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic [rgbseq_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [rgbseq_pkg::CDATA_W-1:0] i_cfg_data
);
    import rgbseq_pkg::*;

    t_cfg w_cfg;
    t_res w_res;
    t_res r_res;
    logic r_valid;
    logic w_ready;
    logic w_fire;

    // register file for timing, length and colour
    rgbseq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // frame sequencer: phase, led and bit counters, colour shifter
    rgbseq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_operation   (i_in.operation),
        .i_pixel_red   (i_in.pixel_red),
        .i_pixel_green (i_in.pixel_green),
        .i_pixel_blue  (i_in.pixel_blue),
        .i_cfg         (w_cfg),
        .o_res         (w_res)
    );

    // accept whenever the result register is empty or being drained
    assign w_ready    = !r_valid || o_out.ready;
    assign w_fire     = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in.valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.symbol_ticks     = r_res.symbol_ticks;
    assign o_out.status           = r_res.status;
    assign o_out.busy_res         = r_res.busy_res;
    assign o_out.pixel_wanted     = r_res.pixel_wanted;
    assign o_out.next_pixel_index = r_res.next_pixel_index;
    assign o_out.frame_done       = r_res.frame_done;

endmodule

@@ dv/rgb_led_bit_slot_sequencer_top_tb.sv @@
`timescale 1ns / 1ps

module rgb_led_bit_slot_sequencer_top_tb;
    import rgbseq_pkg::*;

    // generous bound: every item with a full sender gap and receiver stall, several times over
    localparam int CYCLE_LIMIT = 1_000_000;
    // long receiver hold-off so the result register fills and the input stalls
    localparam int HOLD_CYCLES = 120;
    // index past the register list, writes to it must be ignored
    localparam logic [CIDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_led_request;

    // tracks the frame sequencer and holds the symbols still to come out
    class t_symbol_scoreboard;
        t_cfg                    regs;
        logic [1:0]              frame_phase;
        logic [LED_W-1:0]        led_idx;
        logic [BIT_W-1:0]        bit_idx;
        logic [BITS_PER_LED-1:0] colour;
        logic [SLOT_W-1:0]       slot;
        t_res                    expected_slots[$];
        int                      errors;
        int                      checked;
        int                      frames;
        int                      refused;
        int                      idle_ticks;

        function new();
            regs = '0;
            regs.chain_len = CHAIN_LEN_RST;
            regs.zero_high = ZERO_HIGH_RST;
            regs.one_high = ONE_HIGH_RST;
            frame_phase = PH_IDLE;
            led_idx = '0;
            bit_idx = '0;
            colour = '0;
            slot = '0;
            errors = 0;
            checked = 0;
            frames = 0;
            refused = 0;
            idle_ticks = 0;
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction

        function void apply_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                CFG_CHAIN_LEN: begin
                    if (data == '0)
                        regs.chain_len = LED_W'(1);
                    else if (data > MAX_LEDS_V)
                        regs.chain_len = MAX_LEDS_V;
                    else
                        regs.chain_len = data;
                end
                CFG_ZERO_HIGH: regs.zero_high = data[7:0];
                CFG_ONE_HIGH:  regs.one_high = data[7:0];
                CFG_SOURCE:    regs.source = data[0];
                CFG_RED:       regs.red = data[7:0];
                CFG_GREEN:     regs.green = data[7:0];
                CFG_BLUE:      regs.blue = data[7:0];
                default: ;
            endcase
        endfunction

        function void bump_slot();
            slot = (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);
        endfunction

        // work out the symbol for one accepted request and queue it
        function void note_request(t_led_request r);
            t_res want;
            want = '0;
            if (r.operation == OP_START) begin
                if (frame_phase != PH_IDLE) begin
                    want.status = ST_REFUSED;
                    refused++;
                end else begin
                    want.status = ST_STARTED;
                    frame_phase = PH_DATA;
                    led_idx = '0;
                    bit_idx = '0;
                    colour = '0;
                    slot = '0;
                end
            end else begin
                case (frame_phase)
                    PH_DATA: begin
                        if (bit_idx == '0) begin
                            if (regs.source)
                                colour = {r.green, r.red, r.blue};
                            else
                                colour = {regs.green, regs.red, regs.blue};
                        end
                        want.symbol_ticks = colour[BITS_PER_LED-1] ? regs.one_high
                                                                    : regs.zero_high;
                        colour = colour << 1;
                        bump_slot();
                        if (bit_idx == LAST_BIT) begin
                            bit_idx = '0;
                            led_idx++;
                            if (led_idx >= regs.chain_len)
                                frame_phase = (slot == '0) ? PH_LOW : PH_PAD;
                        end else begin
                            bit_idx++;
                        end
                    end
                    PH_PAD: begin
                        bump_slot();
                        if (slot == '0)
                            frame_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        bump_slot();
                        if (slot == '0) begin
                            want.frame_done = 1'b1;
                            frame_phase = PH_IDLE;
                            frames++;
                        end
                    end
                    default: idle_ticks++;
                endcase
            end
            want.busy_res = (frame_phase != PH_IDLE);
            want.pixel_wanted = (frame_phase == PH_DATA) && (bit_idx == '0) && regs.source;
            want.next_pixel_index = (frame_phase == PH_DATA) ? led_idx[7:0] : 8'd0;
            expected_slots.push_back(want);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_slots.size() == 0) begin
                errors++;
                $display("%0t: result %h with nothing expected", $time, got);
                return;
            end
            want = expected_slots.pop_front();
            checked++;
            report("symbol_ticks", want.symbol_ticks, got.symbol_ticks);
            report("status", want.status, got.status);
            report("busy_res", want.busy_res, got.busy_res);
            report("pixel_wanted", want.pixel_wanted, got.pixel_wanted);
            report("next_pixel_index", want.next_pixel_index, got.next_pixel_index);
            report("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // request side drive
    logic       req_valid = 1'b0;
    logic       req_op = OP_TICK;
    logic [7:0] req_red = '0;
    logic [7:0] req_green = '0;
    logic [7:0] req_blue = '0;

    // result side drive
    logic sink_ready = 1'b0;

    // register write port
    logic               cfg_we = 1'b0;
    logic [CIDX_W-1:0]  cfg_idx = '0;
    logic [CDATA_W-1:0] cfg_data = '0;

    // random idling on both sides, switched off for the last part of the run
    bit gaps_on = 1'b1;
    // main flow bumps holds_asked, the receiver notices and holds off
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int cycle_count = 0;

    t_symbol_scoreboard sb;

    rgbseq_in_if  in_ch ();
    rgbseq_out_if out_ch ();

    assign in_ch.valid = req_valid;
    assign in_ch.operation = req_op;
    assign in_ch.pixel_red = req_red;
    assign in_ch.pixel_green = req_green;
    assign in_ch.pixel_blue = req_blue;
    assign out_ch.ready = sink_ready;

    rgb_led_bit_slot_sequencer_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // receiver: check each taken result, then pick next cycle's ready
    always @(posedge clk) begin
        t_res got;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.symbol_ticks, out_ch.status, out_ch.busy_res,
                       out_ch.pixel_wanted, out_ch.next_pixel_index, out_ch.frame_done};
                sb.check_result(got);
            end
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // long hold-off, counted here while the sender keeps going
                hold_left--;
                sink_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                sink_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                // random stall burst, starting with this cycle
                stall_left = $urandom_range(1, 14) - 1;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // one request: optional idle burst, then hold it until taken
    task automatic send_item(input logic op, input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
        t_led_request r;
        r = {op, red, green, blue};
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op <= op;
        req_red <= red;
        req_green <= green;
        req_blue <= blue;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(r);
    endtask

    task automatic send_random(input logic op);
        send_item(op, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // ticks until the frame in flight has played out
    task automatic finish_frame();
        while (sb.frame_phase != PH_IDLE)
            send_random(OP_TICK);
    endtask

    // whole frames with random colours; noise_pct of the slots become stray starts
    task automatic run_frames(input int count, input int noise_pct);
        for (int f = 0; f < count; f++) begin
            if ($urandom_range(0, 2) == 0)
                send_random(OP_TICK);
            send_random(OP_START);
            while (sb.frame_phase != PH_IDLE)
                send_random(($urandom_range(0, 99) < noise_pct) ? OP_START : OP_TICK);
        end
    endtask

    // drop valid and wait until every symbol is back and the block is quiet
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CDATA_W'(value);
        @(posedge clk);
        sb.apply_reg(idx, CDATA_W'(value));
    endtask

    task automatic program_regs(input int unsigned leds, input int unsigned zero_ticks,
                                input int unsigned one_ticks, input int unsigned source,
                                input int unsigned red, input int unsigned green,
                                input int unsigned blue);
        write_reg(CFG_CHAIN_LEN, leds);
        write_reg(CFG_ZERO_HIGH, zero_ticks);
        write_reg(CFG_ONE_HIGH, one_ticks);
        write_reg(CFG_SOURCE, source);
        write_reg(CFG_RED, red);
        write_reg(CFG_GREEN, green);
        write_reg(CFG_BLUE, blue);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two LEDs from the input, a write to an unused index first
        write_reg(CFG_SPARE, 9'h1FF);
        program_regs(2, ZERO_HIGH_RST, ONE_HIGH_RST, 1, 0, 0, 0);
        // tick with no frame running
        send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_START, 8'h00, 8'h00, 8'h00);
        // second start while busy gets refused
        send_item(OP_START, 8'hFF, 8'hFF, 8'hFF);
        // first bit latches the colour, later samples must be ignored
        send_item(OP_TICK, 8'hFF, 8'h00, 8'hA5);
        for (int k = 0; k < 19; k++)
            send_item(OP_TICK, (k % 2) ? 8'h00 : 8'hFF, (k % 2) ? 8'hFF : 8'h00, 8'h5A);
        finish_frame();

        // led count of zero means one LED; tick values at their extremes;
        // a long receiver hold-off
        settle();
        program_regs(0, 0, 255, 1, 0, 0, 0);
        holds_asked++;
        run_frames(1, 3);

        // exactly one chunk of LEDs: no padding before the low time
        settle();
        program_regs(8, 255, 0, 1, 255, 255, 255);
        run_frames(1, 3);

        // last part runs flat out with uniform colour and padding
        settle();
        gaps_on = 1'b0;
        program_regs(3, $urandom_range(0, 255), $urandom_range(0, 255), 0,
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        run_frames(1, 2);

        settle();
        $display("summary: %0d symbols checked over %0d frames, %0d refused starts",
                 sb.checked, sb.frames, sb.refused);
        $display("summary: %0d idle ticks, chains of 1 to %0d LEDs, both colour sources",
                 sb.idle_ticks, CHUNK_LEDS);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
